>>> rtl/cable_robot_inverse_kinematics_macros.svh
// Assertion macros for the cable robot kinematics RTL
`ifndef CABLE_ROBOT_INVERSE_KINEMATICS_MACROS_SVH
`define CABLE_ROBOT_INVERSE_KINEMATICS_MACROS_SVH

// fail when expr holds at a clock edge out of reset
`define CRIK_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

// fail when ante holds and cons does not at the same edge
`define CRIK_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

>>> rtl/crik_pkg.sv
// Shared types and constants of the cable robot kinematics block
package crik_pkg;

    localparam int COORD_WIDTH_DEF = 20;
    localparam int COORD_MAX_W     = 32;
    localparam int XY_W            = COORD_MAX_W + 1;
    localparam int DIFF_W          = XY_W + 1;
    localparam int ANCHOR_XY_W     = 20;
    localparam int ANCHOR_Z_W      = 16;
    localparam int ANCHOR_W        = 2 * ANCHOR_XY_W + ANCHOR_Z_W;
    localparam int NUM_ANCHORS     = 4;
    localparam int ANCHOR_IDX_W    = $clog2(NUM_ANCHORS);
    localparam int Z_W             = 16;
    localparam int ARM_W           = 16;
    localparam int LEN_W           = 20;
    localparam int MAG_W           = 31;
    localparam int ROOT_W          = 32;
    localparam int RAD_W           = 2 * ROOT_W;
    localparam int CZ_W            = Z_W + 1;
    localparam int QUEUE_DEPTH     = 2;
    localparam int CFG_ADDR_W      = 6;
    localparam int CFG_DATA_W      = 64;

    localparam logic [ARM_W-1:0]  ARM_RESET  = 16'd19635;
    localparam logic [DIFF_W-1:0] DIFF_CLAMP = DIFF_W'(64'd1 << 30);
    localparam logic [ROOT_W-1:0] LEN_MAX    = ROOT_W'((64'd1 << LEN_W) - 64'd1);

    typedef enum logic [2:0] {
        REG_ANCHOR_TL,
        REG_ANCHOR_TR,
        REG_ANCHOR_BL,
        REG_ANCHOR_BR,
        REG_ARM_OFFSET,
        REG_CENTER_X,
        REG_CENTER_Y
    } reg_idx_t;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic                   ready;
    } job_t;

    typedef struct packed {
        logic [NUM_ANCHORS-1:0][ANCHOR_W-1:0] anchor;
        logic [ARM_W-1:0]                     arm;
    } geom_t;

endpackage

>>> rtl/cable_robot_inverse_kinematics.sv
// Top level: configuration registers and the front, queue and back parts
// Inverse kinematics of a four-cable planar robot. A word with belts_ready high
// takes, for each of the four anchors, four squarings on the one shared
// multiplier and two floor square roots on the shared root unit, which resolves
// one bit per cycle. A word with belts_ready low returns the held lengths. A
// two-word queue lets new words enter while the back part works, and one output
// register holds the finished word until it is popped. Registers sit at byte
// address 8*i on a 64-bit APB port; write them only while the block is idle.
module cable_robot_inverse_kinematics
    import crik_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [CFG_ADDR_W-1:0]         paddr,
    input  logic [CFG_DATA_W-1:0]         pwdata,
    output logic [CFG_DATA_W-1:0]         prdata,
    output logic                          pready,
    input  logic                          push,
    output logic                          full,
    input  logic signed [COORD_WIDTH-1:0] pos_x,
    input  logic signed [COORD_WIDTH-1:0] pos_y,
    input  logic signed [Z_W-1:0]         pos_z,
    input  logic                          belts_ready,
    output logic                          empty,
    input  logic                          pop,
    output logic [LEN_W-1:0]              len_top_left,
    output logic [LEN_W-1:0]              len_top_right,
    output logic [LEN_W-1:0]              len_bottom_left,
    output logic [LEN_W-1:0]              len_bottom_right,
    output logic signed [Z_W-1:0]         z_out,
    output logic                          lengths_held
);

    logic [ANCHOR_W-1:0]           anchor_reg [NUM_ANCHORS];
    logic [ARM_W-1:0]              arm_reg;
    logic signed [COORD_WIDTH-1:0] center_x_reg;
    logic signed [COORD_WIDTH-1:0] center_y_reg;
    reg_idx_t                      idx;
    logic                          wr_en;
    geom_t                         geom;
    logic                          q_full, q_push, q_empty, q_pop;
    job_t                          push_job, pop_job;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:3]);
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            anchor_reg   <= '{default: '0};
            arm_reg      <= ARM_RESET;
            center_x_reg <= '0;
            center_y_reg <= '0;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_ANCHOR_TL:  anchor_reg[0] <= pwdata[ANCHOR_W-1:0];
                REG_ANCHOR_TR:  anchor_reg[1] <= pwdata[ANCHOR_W-1:0];
                REG_ANCHOR_BL:  anchor_reg[2] <= pwdata[ANCHOR_W-1:0];
                REG_ANCHOR_BR:  anchor_reg[3] <= pwdata[ANCHOR_W-1:0];
                REG_ARM_OFFSET: arm_reg       <= pwdata[ARM_W-1:0];
                REG_CENTER_X:   center_x_reg  <= pwdata[COORD_WIDTH-1:0];
                REG_CENTER_Y:   center_y_reg  <= pwdata[COORD_WIDTH-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_ANCHOR_TL:  prdata = CFG_DATA_W'(anchor_reg[0]);
            REG_ANCHOR_TR:  prdata = CFG_DATA_W'(anchor_reg[1]);
            REG_ANCHOR_BL:  prdata = CFG_DATA_W'(anchor_reg[2]);
            REG_ANCHOR_BR:  prdata = CFG_DATA_W'(anchor_reg[3]);
            REG_ARM_OFFSET: prdata = CFG_DATA_W'(arm_reg);
            REG_CENTER_X:   prdata = CFG_DATA_W'(center_x_reg);
            REG_CENTER_Y:   prdata = CFG_DATA_W'(center_y_reg);
            default:        prdata = '0;
        endcase
    end

    always_comb
    begin
        geom.anchor[0] = anchor_reg[0];
        geom.anchor[1] = anchor_reg[1];
        geom.anchor[2] = anchor_reg[2];
        geom.anchor[3] = anchor_reg[3];
        geom.arm       = arm_reg;
    end

    crik_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front
    (
        .push        (push),
        .full        (full),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .belts_ready (belts_ready),
        .center_x    (center_x_reg),
        .center_y    (center_y_reg),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_job       (push_job)
    );

    crik_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .pop_job  (pop_job),
        .empty    (q_empty)
    );

    crik_back u_back
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .geom             (geom),
        .q_empty          (q_empty),
        .q_job            (pop_job),
        .q_pop            (q_pop),
        .empty            (empty),
        .pop              (pop),
        .len_top_left     (len_top_left),
        .len_top_right    (len_top_right),
        .len_bottom_left  (len_bottom_left),
        .len_bottom_right (len_bottom_right),
        .z_out            (z_out),
        .lengths_held     (lengths_held)
    );

endmodule

>>> rtl/crik_front.sv
// Input side: accept position words, apply frame center, tag ready or held
module crik_front
    import crik_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                          push,
    output logic                          full,
    input  logic signed [COORD_WIDTH-1:0] pos_x,
    input  logic signed [COORD_WIDTH-1:0] pos_y,
    input  logic signed [Z_W-1:0]         pos_z,
    input  logic                          belts_ready,
    input  logic signed [COORD_WIDTH-1:0] center_x,
    input  logic signed [COORD_WIDTH-1:0] center_y,
    input  logic                          q_full,
    output logic                          q_push,
    output job_t                          q_job
);

    assign full   = q_full;
    assign q_push = push && !q_full;

    always_comb
    begin
        q_job.x     = XY_W'(pos_x) + XY_W'(center_x);
        q_job.y     = XY_W'(pos_y) + XY_W'(center_y);
        q_job.z     = pos_z;
        q_job.ready = belts_ready;
    end

endmodule

>>> rtl/crik_queue.sv
// Short queue of jobs between the front and back parts
module crik_queue
    import crik_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output job_t pop_job,
    output logic empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_job = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

>>> rtl/crik_isqrt.sv
// Iterative floor square root, one result bit per cycle
module crik_isqrt
    import crik_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [RAD_W-1:0]  radicand,
    output logic              busy,
    output logic              done,
    output logic [ROOT_W-1:0] root
);

    localparam int REM_W = ROOT_W + 2;
    localparam int CNT_W = $clog2(ROOT_W);

    logic [RAD_W-1:0]  rad_reg, rad_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [REM_W+1:0]  rem_sh;
    logic [REM_W+1:0]  trial;

    assign busy = busy_reg;
    assign done = done_reg;
    assign root = root_reg;

    always_comb
    begin
        rem_sh    = {rem_reg, rad_reg[RAD_W-1 -: 2]};
        trial     = {2'b00, root_reg, 2'b01};
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = CNT_W'(ROOT_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rad_next = rad_reg << 2;
            if (rem_sh >= trial)
            begin
                rem_next  = REM_W'(rem_sh - trial);
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = REM_W'(rem_sh);
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rad_reg  <= '0;
            rem_reg  <= '0;
            root_reg <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            rad_reg  <= rad_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

endmodule

>>> rtl/crik_back.sv
// Back part: sequence squares and roots per anchor, hold lengths, drive results
`include "cable_robot_inverse_kinematics_macros.svh"
module crik_back
    import crik_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  geom_t                   geom,
    input  logic                    q_empty,
    input  job_t                    q_job,
    output logic                    q_pop,
    output logic                    empty,
    input  logic                    pop,
    output logic [LEN_W-1:0]        len_top_left,
    output logic [LEN_W-1:0]        len_top_right,
    output logic [LEN_W-1:0]        len_bottom_left,
    output logic [LEN_W-1:0]        len_bottom_right,
    output logic signed [Z_W-1:0]   z_out,
    output logic                    lengths_held
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_A,
        S_MUL_B,
        S_ROOT1_GO,
        S_ROOT1,
        S_MUL_C,
        S_MUL_D,
        S_ROOT2_GO,
        S_ROOT2,
        S_OUT
    } state_t;

    state_t                  state_reg, state_next;
    job_t                    job_reg, job_next;
    logic [ANCHOR_IDX_W-1:0] k_reg, k_next;
    logic [RAD_W-1:0]        acc_reg, acc_next;
    logic [ROOT_W-1:0]       planar_reg, planar_next;
    logic [LEN_W-1:0]        last_len_reg [NUM_ANCHORS];
    logic [LEN_W-1:0]        last_len_next [NUM_ANCHORS];
    logic [LEN_W-1:0]        out_len_reg [NUM_ANCHORS];
    logic [LEN_W-1:0]        out_len_next [NUM_ANCHORS];
    logic signed [Z_W-1:0]   out_z_reg, out_z_next;
    logic                    out_held_reg, out_held_next;
    logic                    out_valid_reg, out_valid_next;

    logic [ANCHOR_W-1:0]       anchor;
    logic signed [DIFF_W-1:0]  dx, dy;
    logic [DIFF_W-1:0]         mx, my;
    logic [MAG_W-1:0]          cx, cy;
    logic signed [ROOT_W:0]    belt;
    logic [ROOT_W:0]           belt_abs;
    logic signed [CZ_W-1:0]    cz;
    logic [CZ_W-1:0]           cz_abs;
    logic [ROOT_W-1:0]         sq_op;
    logic [RAD_W-1:0]          sq_prod;
    logic [LEN_W-1:0]          len_sat;
    logic                      sq_start, sq_busy, sq_done;
    logic [ROOT_W-1:0]         sq_root;

    crik_isqrt u_isqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (acc_reg),
        .busy     (sq_busy),
        .done     (sq_done),
        .root     (sq_root)
    );

    always_comb
    begin
        anchor   = geom.anchor[k_reg];
        dx       = DIFF_W'($signed(anchor[ANCHOR_XY_W-1:0])) - DIFF_W'(job_reg.x);
        dy       = DIFF_W'($signed(anchor[2*ANCHOR_XY_W-1:ANCHOR_XY_W])) - DIFF_W'(job_reg.y);
        mx       = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
        my       = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
        cx       = (mx > DIFF_CLAMP) ? MAG_W'(DIFF_CLAMP) : mx[MAG_W-1:0];
        cy       = (my > DIFF_CLAMP) ? MAG_W'(DIFF_CLAMP) : my[MAG_W-1:0];
        belt     = $signed({1'b0, planar_reg}) - $signed((ROOT_W + 1)'(geom.arm));
        belt_abs = belt[ROOT_W] ? (ROOT_W + 1)'(-belt) : (ROOT_W + 1)'(belt);
        cz       = CZ_W'(job_reg.z) + CZ_W'($signed(anchor[ANCHOR_W-1:2*ANCHOR_XY_W]));
        cz_abs   = cz[CZ_W-1] ? CZ_W'(-cz) : CZ_W'(cz);
        case (state_reg)
            S_MUL_A: sq_op = ROOT_W'(cx);
            S_MUL_B: sq_op = ROOT_W'(cy);
            S_MUL_C: sq_op = belt_abs[ROOT_W-1:0];
            S_MUL_D: sq_op = ROOT_W'(cz_abs);
            default: sq_op = '0;
        endcase
        sq_prod = RAD_W'(sq_op) * RAD_W'(sq_op);
        len_sat = (sq_root > LEN_MAX) ? LEN_MAX[LEN_W-1:0] : sq_root[LEN_W-1:0];
    end

    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        k_next         = k_reg;
        acc_next       = acc_reg;
        planar_next    = planar_reg;
        last_len_next  = last_len_reg;
        out_len_next   = out_len_reg;
        out_z_next     = out_z_reg;
        out_held_next  = out_held_reg;
        out_valid_next = out_valid_reg;
        q_pop          = 1'b0;
        sq_start       = 1'b0;
        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop    = 1'b1;
                    job_next = q_job;
                    k_next   = '0;
                    state_next = q_job.ready ? S_MUL_A : S_OUT;
                end
            end
            S_MUL_A:
            begin
                acc_next   = sq_prod;
                state_next = S_MUL_B;
            end
            S_MUL_B:
            begin
                acc_next   = acc_reg + sq_prod;
                state_next = S_ROOT1_GO;
            end
            S_ROOT1_GO:
            begin
                sq_start   = 1'b1;
                state_next = S_ROOT1;
            end
            S_ROOT1:
            begin
                if (sq_done)
                begin
                    planar_next = sq_root;
                    state_next  = S_MUL_C;
                end
            end
            S_MUL_C:
            begin
                acc_next   = sq_prod;
                state_next = S_MUL_D;
            end
            S_MUL_D:
            begin
                acc_next   = acc_reg + sq_prod;
                state_next = S_ROOT2_GO;
            end
            S_ROOT2_GO:
            begin
                sq_start   = 1'b1;
                state_next = S_ROOT2;
            end
            S_ROOT2:
            begin
                if (sq_done)
                begin
                    last_len_next[k_reg] = len_sat;
                    if (k_reg == ANCHOR_IDX_W'(NUM_ANCHORS - 1))
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = S_MUL_A;
                    end
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || pop)
                begin
                    out_valid_next = 1'b1;
                    out_len_next   = last_len_reg;
                    out_z_next     = job_reg.z;
                    out_held_next  = !job_reg.ready;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            job_reg       <= '0;
            k_reg         <= '0;
            acc_reg       <= '0;
            planar_reg    <= '0;
            last_len_reg  <= '{default: '0};
            out_len_reg   <= '{default: '0};
            out_z_reg     <= '0;
            out_held_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            job_reg       <= job_next;
            k_reg         <= k_next;
            acc_reg       <= acc_next;
            planar_reg    <= planar_next;
            last_len_reg  <= last_len_next;
            out_len_reg   <= out_len_next;
            out_z_reg     <= out_z_next;
            out_held_reg  <= out_held_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign empty            = !out_valid_reg;
    assign len_top_left     = out_len_reg[0];
    assign len_top_right    = out_len_reg[1];
    assign len_bottom_left  = out_len_reg[2];
    assign len_bottom_right = out_len_reg[3];
    assign z_out            = out_z_reg;
    assign lengths_held     = out_held_reg;

    `CRIK_ASSERT_NEVER(a_root_restart, sq_start && sq_busy, "root unit restarted while busy")
    `CRIK_ASSERT_IMPLIES(a_root_done_state, sq_done, (state_reg == S_ROOT1) || (state_reg == S_ROOT2), "root finished outside a wait state")
    `CRIK_ASSERT_IMPLIES(a_held_no_math, state_reg == S_MUL_A, job_reg.ready, "lengths computed for a held word")

endmodule

>>> sim/cable_robot_inverse_kinematics_test.sv
// Testbench for cable_robot_inverse_kinematics: random and directed positions vs a belt length model
module cable_robot_inverse_kinematics_test
    import crik_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [LEN_W-1:0]     lens [NUM_ANCHORS];
        logic signed [Z_W-1:0] z;
        logic                  held;
    } belt_word_t;

    class belt_scoreboard;
        logic [ANCHOR_W-1:0]    anchor [NUM_ANCHORS];
        logic [ARM_W-1:0]       arm;
        logic signed [19:0]     cx;
        logic signed [19:0]     cy;
        logic [LEN_W-1:0]       last_lens [NUM_ANCHORS];
        belt_word_t             pending [$];
        int                     errors;

        function new();
            foreach (anchor[i])
            begin
                anchor[i] = '0;
                last_lens[i] = '0;
            end
            arm = ARM_RESET;
            cx = '0;
            cy = '0;
            errors = 0;
        endfunction

        function void set_reg(reg_idx_t idx, logic [63:0] v);
            case (idx)
                REG_ARM_OFFSET: arm = v[15:0];
                REG_CENTER_X:   cx = v[19:0];
                REG_CENTER_Y:   cy = v[19:0];
                default:        anchor[idx] = v[ANCHOR_W-1:0];
            endcase
        endfunction

        function longint unsigned floor_root(longint unsigned v);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v)
                b = b >> 2;
            while (b != 0)
            begin
                if (v >= r + b)
                begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end
                else
                    r = r >> 1;
                b = b >> 2;
            end
            return r;
        endfunction

        function longint unsigned clamp_mag(longint d);
            if (d > 64'sd1073741824)
                d = 64'sd1073741824;
            if (d < -64'sd1073741824)
                d = -64'sd1073741824;
            return d < 0 ? -d : d;
        endfunction

        function logic [LEN_W-1:0] belt_length(logic [ANCHOR_W-1:0] p, longint x, longint y,
                                               longint z);
            logic signed [19:0] axs;
            logic signed [19:0] ays;
            logic signed [15:0] azs;
            longint unsigned a;
            longint unsigned b;
            longint planar;
            longint bl;
            longint c;
            longint unsigned len;
            axs = p[19:0];
            ays = p[39:20];
            azs = p[55:40];
            a = clamp_mag(longint'(axs) - x);
            b = clamp_mag(longint'(ays) - y);
            planar = floor_root(a * a + b * b);
            bl = planar - longint'(arm);
            if (bl < 0)
                bl = -bl;
            c = z + longint'(azs);
            if (c < 0)
                c = -c;
            len = floor_root(bl * bl + c * c);
            return len > 64'd1048575 ? 20'hFFFFF : len[19:0];
        endfunction

        function void note(logic signed [19:0] px, logic signed [19:0] py,
                           logic signed [15:0] pz, logic rdy);
            belt_word_t w;
            if (rdy)
                foreach (last_lens[i])
                    last_lens[i] = belt_length(anchor[i], longint'(px) + longint'(cx),
                                               longint'(py) + longint'(cy), longint'(pz));
            foreach (last_lens[i])
                w.lens[i] = last_lens[i];
            w.z = pz;
            w.held = !rdy;
            pending.push_back(w);
        endfunction

        task report(string what, longint got, longint want);
            $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
            errors++;
        endtask

        task check(belt_word_t got);
            belt_word_t w;
            if (pending.size() == 0)
            begin
                report("unexpected word", 0, 0);
                return;
            end
            w = pending.pop_front();
            foreach (w.lens[i])
                if (got.lens[i] !== w.lens[i])
                    report($sformatf("length %0d", i), got.lens[i], w.lens[i]);
            if (got.z !== w.z)
                report("z_out", got.z, w.z);
            if (got.held !== w.held)
                report("lengths_held", got.held, w.held);
        endtask
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic pready;
    logic push = 0;
    logic full;
    logic signed [19:0] pos_x = '0, pos_y = '0;
    logic signed [Z_W-1:0] pos_z = '0;
    logic belts_ready = 0;
    logic empty;
    logic pop = 0;
    logic [LEN_W-1:0] len_tl, len_tr, len_bl, len_br;
    logic signed [Z_W-1:0] z_out;
    logic lengths_held;

    belt_scoreboard sb = new();
    int send_idle = 0, recv_idle = 0;
    int hold_cnt = 0;
    bit hold_req = 0;
    int quiet = 0;

    cable_robot_inverse_kinematics dut (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .push(push), .full(full), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .belts_ready(belts_ready), .empty(empty), .pop(pop),
        .len_top_left(len_tl), .len_top_right(len_tr), .len_bottom_left(len_bl),
        .len_bottom_right(len_br), .z_out(z_out), .lengths_held(lengths_held)
    );

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_cnt = 1000;
            hold_req = 0;
        end
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            pop <= 0;
        end
        else
            pop <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge clk)
    begin
        belt_word_t got;
        if (rst_n && pop && !empty)
        begin
            got.lens[0] = len_tl;
            got.lens[1] = len_tr;
            got.lens[2] = len_bl;
            got.lens[3] = len_br;
            got.z = z_out;
            got.held = lengths_held;
            sb.check(got);
        end
        if ((pop && !empty) || (push && !full) || !rst_n)
            quiet = 0;
        else
            quiet++;
        if (quiet >= 20000)
        begin
            $display("cable_robot_inverse_kinematics verification failed");
            $finish;
        end
    end

    task write_reg(reg_idx_t idx, logic [63:0] v);
        @(negedge clk);
        psel <= 1;
        pwrite <= 1;
        paddr <= CFG_ADDR_W'(idx) << 3;
        pwdata <= v;
        @(negedge clk);
        penable <= 1;
        @(negedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        sb.set_reg(idx, v);
    endtask

    task send_word(logic signed [19:0] x, logic signed [19:0] y, logic signed [15:0] z,
                   logic rdy);
        @(negedge clk);
        if ($urandom_range(99) < send_idle)
        begin
            push <= 0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        push <= 1;
        pos_x <= x;
        pos_y <= y;
        pos_z <= z;
        belts_ready <= rdy;
        do
            @(posedge clk);
        while (full);
        sb.note(x, y, z, rdy);
    endtask

    task drain();
        @(negedge clk);
        push <= 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    function logic [63:0] pack_anchor(logic [19:0] ax, logic [19:0] ay, logic [15:0] az);
        return {8'd0, az, ay, ax};
    endfunction

    task load_geometry(bit wide);
        for (int i = 0; i < NUM_ANCHORS; i++)
            if (wide)
                write_reg(reg_idx_t'(i), {8'd0, 56'($urandom()) << 24 | 56'($urandom())});
            else
                write_reg(reg_idx_t'(i), pack_anchor(20'($urandom_range(0, 262143) - 131072),
                    20'($urandom_range(0, 262143) - 131072), 16'($urandom_range(0, 8191) - 4096)));
        write_reg(REG_ARM_OFFSET, $urandom_range(0, 30000));
        write_reg(REG_CENTER_X, 64'(signed'(20'($urandom_range(0, 4095) - 2048))));
        write_reg(REG_CENTER_Y, 64'(signed'(20'($urandom_range(0, 4095) - 2048))));
    endtask

    task random_words(int n);
        logic rdy;
        for (int k = 0; k < n; k++)
        begin
            rdy = ($urandom_range(99) < 80);
            if ($urandom_range(9) < 2)
                send_word(20'($urandom()), 20'($urandom()), 16'($urandom()), rdy);
            else
                send_word(20'($urandom_range(0, 131071) - 65536),
                          20'($urandom_range(0, 131071) - 65536),
                          16'($urandom_range(0, 4095) - 2048), rdy);
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;

        send_idle = 11;
        recv_idle = 49;
        send_word(20'sd100, -20'sd100, 16'sd5, 0);
        send_word(20'sd0, 20'sd0, 16'sd0, 1);
        send_word(20'sd0, 20'sd0, 16'sd0, 0);
        send_word(20'sd524287, 20'sd524287, 16'sd32767, 1);
        send_word(-20'sd524288, -20'sd524288, -16'sd32768, 1);
        send_word(20'sd524287, -20'sd524288, 16'sd0, 1);
        send_word(20'sd1000, 20'sd2000, -16'sd300, 1);
        send_word(-20'sd7, 20'sd9, 16'sd1, 0);
        drain();
        write_reg(REG_ANCHOR_TL, pack_anchor(20'h7FFFF, 20'h7FFFF, 16'h7FFF));
        write_reg(REG_ANCHOR_TR, pack_anchor(20'h80000, 20'h80000, 16'h8000));
        write_reg(REG_ANCHOR_BL, pack_anchor(20'h80000, 20'h7FFFF, 16'h0000));
        write_reg(REG_ANCHOR_BR, pack_anchor(20'h00000, 20'h00000, 16'h0000));
        write_reg(REG_ARM_OFFSET, 64'hFFFF);
        write_reg(REG_CENTER_X, 64'(signed'(20'h7FFFF)));
        write_reg(REG_CENTER_Y, 64'(signed'(20'h80000)));
        send_word(20'sd0, 20'sd0, 16'sd0, 1);
        send_word(20'sd524287, -20'sd524288, 16'sd32767, 1);
        send_word(-20'sd524288, 20'sd524287, -16'sd32768, 1);
        send_word(20'sd0, 20'sd0, 16'sd0, 0);
        random_words(40);
        drain();
        write_reg(REG_ARM_OFFSET, 64'd0);
        write_reg(REG_CENTER_X, 64'(signed'(20'h80000)));
        write_reg(REG_CENTER_Y, 64'(signed'(20'h7FFFF)));
        random_words(40);
        drain();
        load_geometry(0);
        random_words(150);
        drain();

        send_idle = 49;
        recv_idle = 11;
        load_geometry(1);
        random_words(100);
        drain();
        load_geometry(0);
        random_words(150);
        drain();

        send_idle = 0;
        recv_idle = 0;
        load_geometry(0);
        hold_req = 1;
        random_words(300);
        drain();

        repeat (400) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("cable_robot_inverse_kinematics verification clean");
        else
            $display("cable_robot_inverse_kinematics verification failed");
        $finish;
    end
endmodule
